>>> hdl/cbte_pkg.sv
// ----------------------------------------------------------------------------
// cbte_pkg
// types and constants shared by the compact binary token encoder
// ----------------------------------------------------------------------------
`default_nettype none

package cbte_pkg;

  // token selector carried by req_type
  typedef enum logic [2:0] {
    REQ_BYTE   = 3'd0,
    REQ_BOOL   = 3'd1,
    REQ_FIELD  = 3'd2,
    REQ_LIST   = 3'd3,
    REQ_INT16  = 3'd4,
    REQ_ZZ32   = 3'd5,
    REQ_ZZ64   = 3'd6,
    REQ_UVAR   = 3'd7
  } req_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PRE  = 2'd1,
    ST_RAW  = 2'd2,
    ST_VAR  = 2'd3
  } state_t;

  // what follows the leading byte of a token
  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_RAW  = 2'd1,
    TAIL_VAR  = 2'd2
  } tail_t;

  localparam logic [7:0]  BOOL_TRUE      = 8'h11;
  localparam logic [7:0]  BOOL_FALSE     = 8'h12;
  localparam logic [3:0]  LIST_LONG_NIB  = 4'hF;
  localparam logic [30:0] LIST_SHORT_MAX = 31'd14;
  localparam logic [3:0]  TYPE_MIN       = 4'd2;
  localparam logic [3:0]  TYPE_MAX       = 4'd12;
  localparam logic [3:0]  TYPE_UNKNOWN   = 4'd0;
  localparam int unsigned GROUP_BITS     = 7;

endpackage

`default_nettype wire

>>> hdl/cbte_if.sv
// ----------------------------------------------------------------------------
// cbte channel interfaces
// valid/ready channels for token items in and encoded bytes out
// ----------------------------------------------------------------------------
`default_nettype none

interface cbte_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [3:0]         wire_type;
  logic signed [15:0] field_id;
  logic signed [15:0] prev_field_id;
  logic [30:0]        element_count;
  logic [63:0]        payload;

  modport source (
    output valid, req_type, wire_type, field_id, prev_field_id, element_count, payload,
    input  ready
  );
  modport sink (
    input  valid, req_type, wire_type, field_id, prev_field_id, element_count, payload,
    output ready
  );
endinterface

interface cbte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/compact_binary_token_encoder_top.sv
// ----------------------------------------------------------------------------
// compact_binary_token_encoder_top
// encodes one compact-binary token per item into a run of 1 to 10 bytes
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      req_type, wire_type, field_id,
//                                    prev_field_id, element_count, payload
//  out_ch    out  valid / ready      out_byte, last_byte (one item per byte)
//
//  - an item is decoded when it is accepted, then its output bytes go out one at a time
//  - varint bytes come from the 7-bit group shifter, one group per cycle unless out_ch stalls
//  - in_ch.ready is high only while the sequencer is idle
//  - the output register lets the last byte wait while the next item enters
//  - a stalled out_ch holds the sequencer in place, nothing is dropped
//  - rst_n is synchronous, active low, and clears the sequencer and out valid
//
`default_nettype none

module compact_binary_token_encoder_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbte_in_if.sink     in_ch,
  cbte_out_if.source  out_ch
);
  import cbte_pkg::*;

  // sequencer and shifter state
  state_t      state_r, state_nxt;
  tail_t       tail_r, tail_nxt;
  logic [7:0]  pre_r, pre_nxt;
  logic [63:0] val_r, val_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  // decode of the incoming item
  state_t      dec_state;
  tail_t       dec_tail;
  logic [7:0]  dec_pre;
  logic [63:0] dec_val;
  logic [3:0]  elem_type;
  logic signed [16:0] delta;
  logic        delta_short;
  logic [63:0] fid_ext;
  logic [63:0] fid_zz;
  logic [63:0] pay_zz64;
  logic [63:0] pay_zz32;

  logic        accept;
  logic        can_load;
  logic        var_more;

  assign accept   = in_ch.valid && in_ch.ready;
  assign can_load = !out_valid_r || out_ch.ready;
  assign var_more = |val_r[63:GROUP_BITS];

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last_byte = out_last_r;

  // header element type, unknown codes fold to zero
  assign elem_type = (in_ch.wire_type >= TYPE_MIN && in_ch.wire_type <= TYPE_MAX)
                     ? in_ch.wire_type : TYPE_UNKNOWN;

  // exact signed delta, short form only for 1..15
  assign delta       = {in_ch.field_id[15], in_ch.field_id}
                     - {in_ch.prev_field_id[15], in_ch.prev_field_id};
  assign delta_short = !delta[16] && (delta[15:4] == 12'd0) && (delta[3:0] != 4'd0);

  // zigzag forms
  assign fid_ext  = {{48{in_ch.field_id[15]}}, in_ch.field_id};
  assign fid_zz   = {fid_ext[62:0], 1'b0} ^ {64{fid_ext[63]}};
  assign pay_zz64 = {in_ch.payload[62:0], 1'b0} ^ {64{in_ch.payload[63]}};
  assign pay_zz32 = {32'd0, {in_ch.payload[30:0], 1'b0} ^ {32{in_ch.payload[31]}}};

  always_comb begin
    dec_state = ST_PRE;
    dec_tail  = TAIL_NONE;
    dec_pre   = 8'd0;
    dec_val   = 64'd0;
    unique case (req_t'(in_ch.req_type))
      REQ_BYTE: begin
        dec_pre = in_ch.payload[7:0];
      end
      REQ_BOOL: begin
        dec_pre = in_ch.payload[0] ? BOOL_TRUE : BOOL_FALSE;
      end
      REQ_FIELD: begin
        if (delta_short) begin
          dec_pre = {delta[3:0], elem_type};
        end else begin
          dec_pre  = {4'd0, elem_type};
          dec_tail = TAIL_VAR;
          dec_val  = fid_zz;
        end
      end
      REQ_LIST: begin
        if (in_ch.element_count <= LIST_SHORT_MAX) begin
          dec_pre = {in_ch.element_count[3:0], elem_type};
        end else begin
          dec_pre  = {LIST_LONG_NIB, elem_type};
          dec_tail = TAIL_VAR;
          dec_val  = {33'd0, in_ch.element_count};
        end
      end
      REQ_INT16: begin
        // big-endian: high byte leads, low byte closes the run
        dec_pre  = in_ch.payload[15:8];
        dec_tail = TAIL_RAW;
        dec_val  = {56'd0, in_ch.payload[7:0]};
      end
      REQ_ZZ32: begin
        dec_state = ST_VAR;
        dec_val   = pay_zz32;
      end
      REQ_ZZ64: begin
        dec_state = ST_VAR;
        dec_val   = pay_zz64;
      end
      REQ_UVAR: begin
        dec_state = ST_VAR;
        dec_val   = in_ch.payload;
      end
      default: begin
        dec_state = ST_PRE;
      end
    endcase
  end

  // sequencer: next state and output register loads
  always_comb begin
    state_nxt     = state_r;
    tail_nxt      = tail_r;
    pre_nxt       = pre_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = dec_state;
          tail_nxt  = dec_tail;
          pre_nxt   = dec_pre;
          val_nxt   = dec_val;
        end
      end
      ST_PRE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pre_r;
          out_last_nxt  = (tail_r == TAIL_NONE);
          unique case (tail_r)
            TAIL_RAW: state_nxt = ST_RAW;
            TAIL_VAR: state_nxt = ST_VAR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RAW: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = val_r[7:0];
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_VAR: begin
        // one 7-bit group per cycle while the output can load, continuation bit set while more remain
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = {var_more, val_r[GROUP_BITS-1:0]};
          out_last_nxt  = !var_more;
          val_nxt       = val_r >> GROUP_BITS;
          if (!var_more) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tail_r     <= tail_nxt;
    pre_r      <= pre_nxt;
    val_r      <= val_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  // an accepted item always starts a run
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after an item");

  // the final varint group closes the run with continuation clear
  a_var_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VAR && can_load && !var_more)
      |=> out_valid_r && out_last_r && !out_byte_r[7] && state_r == ST_IDLE)
    else $error("varint run did not close correctly");

  // a middle varint group carries the continuation bit and no last flag
  a_var_more: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VAR && can_load && var_more)
      |=> out_valid_r && !out_last_r && out_byte_r[7] && state_r == ST_VAR)
    else $error("varint continuation lost");

  // a lead byte with a tail never carries the last flag
  a_pre_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PRE && can_load && tail_r != TAIL_NONE) |=> !out_last_r)
    else $error("lead byte flagged last before its tail");

endmodule

`default_nettype wire

>>> dv/tb_compact_binary_token_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compact_binary_token_encoder_top
// drives token items into the encoder and checks every output byte in order
// against a behavioral encoder, under random source gaps and sink stalls
// ----------------------------------------------------------------------------

module tb_compact_binary_token_encoder_top;

  import cbte_pkg::*;

  // run sizing
  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 6;
  localparam int unsigned RANDOM_ITEMS  = 500;
  localparam int unsigned MAX_IDLE      = 6;
  localparam int unsigned BURST_SPAN    = 40;
  localparam int unsigned HOLD_AT_BYTE  = 200;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 24;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned REPORT_MAX    = 10;

  // one token as the input channel carries it
  typedef struct {
    req_t               req;
    logic [3:0]         wire_type;
    logic signed [15:0] field_id;
    logic signed [15:0] prev_field_id;
    logic [30:0]        element_count;
    logic [63:0]        payload;
  } token_t;

  // one encoded byte as the output channel carries it
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  // directed row: token plus the byte run typed in by hand (nbytes 0 = predict)
  typedef struct {
    token_t      tok;
    int unsigned nbytes;
    logic [79:0] bytes;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cbte_in_if  in_ch ();
  cbte_out_if out_ch ();

  compact_binary_token_encoder_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // bytes still owed by the block, oldest first
  enc_byte_t   pending_bytes[$];
  // byte run of the token about to be offered
  logic [7:0]  token_run[$];
  dir_row_t    directed_rows[$];
  int unsigned mismatch_count = 0;

  // --------------------------------------------------------------------------
  // behavioral encoder
  // --------------------------------------------------------------------------

  function automatic logic [63:0] zigzag64(input logic [63:0] v);
    return (v << 1) ^ {64{v[63]}};
  endfunction

  // 32-bit zigzag stays within 32 bits
  function automatic logic [31:0] zigzag32(input logic [31:0] v);
    return {v[30:0], 1'b0} ^ {32{v[31]}};
  endfunction

  // 7-bit groups, low group first, continuation bit on all but the last
  task automatic run_varint(input logic [63:0] v);
    logic [63:0] rest;
    rest = v;
    while (rest > 64'h7F) begin
      token_run.push_back({1'b1, rest[6:0]});
      rest = rest >> GROUP_BITS;
    end
    token_run.push_back({1'b0, rest[6:0]});
  endtask

  // fills token_run with the bytes one token should produce
  task automatic encode_token(input token_t t);
    logic [3:0]         tcode;
    logic signed [16:0] delta;
    token_run.delete();
    // element type codes outside the known range fold to zero
    tcode = (t.wire_type >= TYPE_MIN && t.wire_type <= TYPE_MAX) ? t.wire_type
                                                                 : TYPE_UNKNOWN;
    // exact signed difference, one bit wider than the ids so nothing wraps
    delta = {t.field_id[15], t.field_id} - {t.prev_field_id[15], t.prev_field_id};
    case (t.req)
      REQ_BYTE:  token_run.push_back(t.payload[7:0]);
      REQ_BOOL:  token_run.push_back(t.payload[0] ? BOOL_TRUE : BOOL_FALSE);
      REQ_FIELD: begin
        if (delta > 17'sd0 && delta < 17'sd16) begin
          token_run.push_back({delta[3:0], tcode});
        end else begin
          // long form: bare type, then zigzag of the sign-extended id
          token_run.push_back({4'h0, tcode});
          run_varint(zigzag64({{48{t.field_id[15]}}, t.field_id}));
        end
      end
      REQ_LIST: begin
        if (t.element_count <= LIST_SHORT_MAX) begin
          token_run.push_back({t.element_count[3:0], tcode});
        end else begin
          // long header byte goes out ahead of the count
          token_run.push_back({LIST_LONG_NIB, tcode});
          run_varint({33'd0, t.element_count});
        end
      end
      REQ_INT16: begin
        token_run.push_back(t.payload[15:8]);
        token_run.push_back(t.payload[7:0]);
      end
      REQ_ZZ32: run_varint({32'd0, zigzag32(t.payload[31:0])});
      REQ_ZZ64: run_varint(zigzag64(t.payload));
      default:  run_varint(t.payload);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // source side
  // --------------------------------------------------------------------------

  task automatic add_row(input req_t req, input logic [3:0] wt,
                         input logic [15:0] fid, input logic [15:0] pid,
                         input logic [30:0] cnt, input logic [63:0] pay,
                         input int unsigned nbytes, input logic [79:0] bytes);
    dir_row_t row;
    row.tok.req           = req;
    row.tok.wire_type     = wt;
    row.tok.field_id      = fid;
    row.tok.prev_field_id = pid;
    row.tok.element_count = cnt;
    row.tok.payload       = pay;
    row.nbytes            = nbytes;
    row.bytes             = bytes;
    directed_rows.push_back(row);
  endtask

  // offers one token after a gap; token_run must already hold its bytes.
  // valid stays high across back-to-back items so it is never lowered and
  // raised in the same step
  task automatic offer_token(input token_t t, input int unsigned gap);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= t.req;
    in_ch.wire_type     <= t.wire_type;
    in_ch.field_id      <= t.field_id;
    in_ch.prev_field_id <= t.prev_field_id;
    in_ch.element_count <= t.element_count;
    in_ch.payload       <= t.payload;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // accepted at this edge: the whole run is now owed
    foreach (token_run[i]) begin
      pending_bytes.push_back({token_run[i], i == token_run.size() - 1});
    end
  endtask

  initial begin : token_source
    token_t      tok;
    int unsigned gap;
    int unsigned shift;
    logic [63:0] r64;
    bit          src_burst;

    // every input known from time zero
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_BYTE;
    in_ch.wire_type     = '0;
    in_ch.field_id      = '0;
    in_ch.prev_field_id = '0;
    in_ch.element_count = '0;
    in_ch.payload       = '0;
    src_burst           = 1'b0;

    // directed table: type / wire type / field id / prev id / count / payload,
    // then the typed byte run in emission order where it is obvious
    add_row(REQ_BYTE,  4'd0,  16'h0000, 16'h0000, 31'd0, 64'h0, 1, 80'h00);
    // bits above the byte are ignored
    add_row(REQ_BYTE,  4'hF,  16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF,
            64'hDEAD_BEEF_CAFE_12FF, 1, 80'hFF);
    add_row(REQ_BOOL,  4'd0,  16'h0000, 16'h0000, 31'd0, 64'h1, 1, 80'h11);
    add_row(REQ_BOOL,  4'hF,  16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF,
            64'hFFFF_FFFF_FFFF_FFFE, 1, 80'h12);
    // short field headers, smallest and largest delta
    add_row(REQ_FIELD, 4'd5,  16'd5,    16'd4,    31'd0, 64'h0, 1, 80'h15);
    add_row(REQ_FIELD, 4'd12, 16'd15,   16'd0,    31'd0, 64'h0, 1, 80'hFC);
    // zero delta falls to the long form
    add_row(REQ_FIELD, 4'd8,  16'd3,    16'd3,    31'd0, 64'h0, 2, 80'h0806);
    // negative delta
    add_row(REQ_FIELD, 4'd3,  16'hFFFF, 16'd2,    31'd0, 64'h0, 2, 80'h0301);
    // delta just past the short range
    add_row(REQ_FIELD, 4'd2,  16'd16,   16'd0,    31'd0, 64'h0, 2, 80'h0220);
    // id extremes, unknown type codes, deltas that would alias if wrapped
    add_row(REQ_FIELD, 4'd13, 16'h7FFF, 16'h8000, 31'd0, 64'h0, 0, '0);
    add_row(REQ_FIELD, 4'd1,  16'h8000, 16'h7FFF, 31'd0, 64'h0, 0, '0);
    add_row(REQ_FIELD, 4'd9,  16'h0101, 16'h0000, 31'd0, 64'h0, 0, '0);
    // list headers around the short/long boundary and at the max count
    add_row(REQ_LIST,  4'd2,  16'h0000, 16'h0000, 31'd0,  64'h0, 1, 80'h02);
    add_row(REQ_LIST,  4'd12, 16'h0000, 16'h0000, 31'd14, 64'h0, 1, 80'hEC);
    add_row(REQ_LIST,  4'd15, 16'h0000, 16'h0000, 31'd15, 64'h0, 2, 80'hF00F);
    add_row(REQ_LIST,  4'd7,  16'h0000, 16'h0000, 31'h7FFF_FFFF, 64'h0, 0, '0);
    // int16 is big endian, upper payload bits ignored
    add_row(REQ_INT16, 4'd0,  16'h0000, 16'h0000, 31'd0,
            64'h0000_0000_0000_8001, 2, 80'h8001);
    add_row(REQ_INT16, 4'd0,  16'h0000, 16'h0000, 31'd0,
            64'hFFFF_FFFF_FFFF_7FFF, 2, 80'h7FFF);
    // 32-bit zigzag extremes
    add_row(REQ_ZZ32,  4'd0,  16'h0000, 16'h0000, 31'd0, 64'h0, 1, 80'h00);
    add_row(REQ_ZZ32,  4'd0,  16'h0000, 16'h0000, 31'd0,
            64'h1234_5678_FFFF_FFFF, 1, 80'h01);
    add_row(REQ_ZZ32,  4'd0,  16'h0000, 16'h0000, 31'd0,
            64'h0000_0000_7FFF_FFFF, 0, '0);
    add_row(REQ_ZZ32,  4'd0,  16'h0000, 16'h0000, 31'd0,
            64'hFFFF_FFFF_8000_0000, 0, '0);
    // 64-bit zigzag extremes, the most negative one is a ten-byte run
    add_row(REQ_ZZ64,  4'd0,  16'h0000, 16'h0000, 31'd0,
            64'hFFFF_FFFF_FFFF_FFFF, 1, 80'h01);
    add_row(REQ_ZZ64,  4'd0,  16'h0000, 16'h0000, 31'd0,
            64'h8000_0000_0000_0000, 0, '0);
    // unsigned varint around the first group boundary and at all ones
    add_row(REQ_UVAR,  4'd0,  16'h0000, 16'h0000, 31'd0, 64'd127, 1, 80'h7F);
    add_row(REQ_UVAR,  4'd0,  16'h0000, 16'h0000, 31'd0, 64'd128, 2, 80'h8001);
    add_row(REQ_UVAR,  4'd0,  16'h0000, 16'h0000, 31'd0,
            64'hFFFF_FFFF_FFFF_FFFF, 0, '0);

    // synchronous reset, once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].nbytes == 0) begin
        encode_token(directed_rows[r].tok);
      end else begin
        token_run.delete();
        for (int unsigned i = 0; i < directed_rows[r].nbytes; i++) begin
          token_run.push_back(
            directed_rows[r].bytes[(directed_rows[r].nbytes - 1 - i) * 8 +: 8]);
        end
      end
      offer_token(directed_rows[r].tok, $urandom_range(0, MAX_IDLE));
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // some spans of items go out back to back with no gaps
      if (n % BURST_SPAN == 0) begin
        src_burst = ($urandom_range(0, 3) == 0);
      end
      tok.req           = req_t'($urandom_range(0, 7));
      tok.wire_type     = 4'($urandom_range(0, 15));
      tok.prev_field_id = 16'($urandom);

      // payload magnitude spread so every varint length shows up
      r64   = {$urandom, $urandom};
      shift = $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0:       tok.payload = r64;
        1:       tok.payload = r64 >> shift;
        2:       tok.payload = ~(r64 >> shift);
        default: tok.payload = {32'hFFFF_FFFF, ~($urandom >> $urandom_range(0, 31))};
      endcase

      // field ids: mostly near the previous id so both header forms appear
      case ($urandom_range(0, 2))
        0:       tok.field_id = tok.prev_field_id + 16'($urandom_range(1, 15));
        1:       tok.field_id = tok.prev_field_id + 16'($urandom_range(0, 40)) - 16'd20;
        default: tok.field_id = 16'($urandom);
      endcase

      // counts: short form often, long form at every length
      case ($urandom_range(0, 2))
        0:       tok.element_count = 31'($urandom_range(0, 20));
        1:       tok.element_count = 31'($urandom >> $urandom_range(1, 31));
        default: tok.element_count = 31'($urandom);
      endcase

      encode_token(tok);
      gap = src_burst ? 0 : $urandom_range(0, MAX_IDLE);
      offer_token(tok, gap);
    end
    in_ch.valid <= 1'b0;

    // let every owed byte come out, then watch for strays
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // sink side
  // --------------------------------------------------------------------------

  // random stall per byte, burst spans with none, and one long hold-off so
  // the block backs up and drops in_ch.ready while the source keeps offering
  initial begin : byte_sink
    int unsigned stall;
    int unsigned taken;
    bit          hold_done;
    bit          sink_burst;
    out_ch.ready = 1'b0;
    taken        = 0;
    hold_done    = 1'b0;
    sink_burst   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % BURST_SPAN == 0) begin
        sink_burst = ($urandom_range(0, 3) == 0);
      end
      if (!hold_done && taken >= HOLD_AT_BYTE) begin
        stall     = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall = sink_burst ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      taken++;
    end
  end

  // compare every accepted byte with the oldest one owed
  always @(posedge clk) begin : byte_check
    enc_byte_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected byte %02h last %0b, nothing owed",
                   out_ch.out_byte, out_ch.last_byte);
        end
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.out_byte !== want.value || out_ch.last_byte !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("byte mismatch: got %02h last %0b, expected %02h last %0b",
                     out_ch.out_byte, out_ch.last_byte, want.value, want.last);
          end
        end
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin : cycle_watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
